// ===== design/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

	localparam int CAPACITY  = 32;
	localparam int NODE_BITS = 8;
	localparam int PRIO_BITS = 16;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic [NODE_BITS-1:0] node;
		logic [NODE_BITS-1:0] parent;
		logic [PRIO_BITS-1:0] prio;
	} entry_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_UPDATE = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		D_ZERO  = 2'd0,
		D_HEAD  = 2'd1,
		D_MATCH = 2'd2
	} dsel_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_EXEC  = 2'd1,
		S_REINS = 2'd2
	} state_t;

	// queue condition seen by the sequencer
	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic empty;
		logic full;
		logic found;
		logic out_free;
	} ctrl_in_t;

	// commands from the sequencer
	typedef struct packed {
		logic    in_ready;
		cmd_t    cmd;
		logic    rm_head;
		logic    out_load;
		status_t status;
		dsel_t   dsel;
	} ctrl_out_t;

endpackage
`default_nettype wire

// ===== design/spq_cell.sv =====
`default_nettype none
module spq_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire spq_pkg::cmd_t  cmd,
	input  wire logic           rm_head,
	input  wire spq_pkg::entry_t new_entry,
	input  wire spq_pkg::entry_t left_entry,
	input  wire logic           left_valid,
	input  wire logic           left_after,
	input  wire spq_pkg::entry_t right_entry,
	input  wire logic           right_valid,
	input  wire logic           seen_in,
	output spq_pkg::entry_t     entry,
	output logic                valid,
	output logic                after,
	output logic                seen_out,
	output logic                first
);

	spq_pkg::entry_t entry_q;
	logic            valid_q;
	logic            match;
	logic            rm;

	// insertion point: first cell that is empty or holds a larger priority
	assign after    = !valid_q || (entry_q.prio > new_entry.prio);
	assign match    = valid_q && (entry_q.node == new_entry.node);
	assign seen_out = seen_in | match;
	assign first    = match & ~seen_in;
	assign rm       = rm_head | seen_out;

	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd)
				spq_pkg::CMD_INSERT: begin
					if (after)
						valid_q <= left_after ? left_valid : 1'b1;
				end
				spq_pkg::CMD_REMOVE: begin
					if (rm)
						valid_q <= right_valid;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			spq_pkg::CMD_INSERT: begin
				if (after)
					entry_q <= left_after ? left_entry : new_entry;
			end
			spq_pkg::CMD_REMOVE: begin
				if (rm)
					entry_q <= right_entry;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/spq_ctrl.sv =====
`default_nettype none
module spq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spq_pkg::ctrl_in_t ci,
	output spq_pkg::ctrl_out_t     co
);

	spq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= spq_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (ci.in_valid)
					state_d = spq_pkg::S_EXEC;
			end
			spq_pkg::S_EXEC: begin
				if (ci.op == spq_pkg::OP_UPDATE && ci.found)
					state_d = spq_pkg::S_REINS;
				else if (ci.out_free)
					state_d = spq_pkg::S_IDLE;
			end
			spq_pkg::S_REINS: begin
				if (ci.out_free)
					state_d = spq_pkg::S_IDLE;
			end
			default: state_d = spq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		co          = '0;
		co.cmd      = spq_pkg::CMD_NONE;
		co.status   = spq_pkg::ST_OK;
		co.dsel     = spq_pkg::D_ZERO;
		unique case (state_q)
			spq_pkg::S_IDLE: co.in_ready = 1'b1;
			spq_pkg::S_EXEC: begin
				if (ci.op == spq_pkg::OP_UPDATE && ci.found) begin
					// take the old entry out first, result comes after re-insert
					co.cmd = spq_pkg::CMD_REMOVE;
				end else if (ci.out_free) begin
					co.out_load = 1'b1;
					unique case (ci.op)
						spq_pkg::OP_INSERT: begin
							if (ci.full)
								co.status = spq_pkg::ST_FULL;
							else
								co.cmd = spq_pkg::CMD_INSERT;
						end
						spq_pkg::OP_POP: begin
							if (ci.empty) begin
								co.status = spq_pkg::ST_EMPTY;
							end else begin
								co.cmd     = spq_pkg::CMD_REMOVE;
								co.rm_head = 1'b1;
								co.dsel    = spq_pkg::D_HEAD;
							end
						end
						spq_pkg::OP_LOOKUP: begin
							if (ci.found)
								co.dsel = spq_pkg::D_MATCH;
							else
								co.status = spq_pkg::ST_NOTFOUND;
						end
						default: co.status = spq_pkg::ST_NOTFOUND;
					endcase
				end
			end
			spq_pkg::S_REINS: begin
				if (ci.out_free) begin
					co.cmd      = spq_pkg::CMD_INSERT;
					co.out_load = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/stable_sorted_priority_queue_core.sv =====
// Sorted priority queue of (node, parent, priority) entries, smallest priority
// at the head; equal priorities keep arrival order.
// Input channel: in_valid/in_ready with operation, node_in, parent_in,
// priority_in (insert, pop minimum, update, lookup).
// Output channel: out_valid/out_ready with status, node_out, parent_out,
// priority_out and entry_count; exactly one result item per input item.
// Storage is a row of cells; each cell compares against the operand and takes
// its left or right neighbor's entry, so all cells move together in an insert
// or removal. Sequence: an item is taken in the idle state and executed in
// the execute state that follows, where its result is registered; a new item
// is taken only once the block is back in idle. An update removes in execute
// and re-inserts in the re-insert state, where its result is registered.
// A result waits in the output register while out_ready is low; the block
// finishes the current item only once that register is free, holding in_ready
// low meanwhile. An insert into a full queue is dropped with status full.
// Reset (arst_n low) empties the queue; no clearing pass is needed.
`default_nettype none
module stable_sorted_priority_queue_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  node_in,
	input  wire logic [7:0]  parent_in,
	input  wire logic [15:0] priority_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [7:0]       node_out,
	output logic [7:0]       parent_out,
	output logic [15:0]      priority_out,
	output logic [5:0]       entry_count
);

	localparam int N = spq_pkg::CAPACITY;

	spq_pkg::op_t       op_q;
	spq_pkg::entry_t    opnd_q;
	logic [spq_pkg::CNT_W-1:0] held_q;

	spq_pkg::ctrl_in_t  ci;
	spq_pkg::ctrl_out_t co;

	spq_pkg::entry_t cell_entry [N];
	logic [N-1:0]    cell_valid;
	logic [N-1:0]    cell_after;
	logic [N-1:0]    cell_seen;
	logic [N-1:0]    cell_first;

	spq_pkg::entry_t match_entry;
	spq_pkg::entry_t res_entry;

	logic                out_valid_q;
	spq_pkg::status_t    status_q;
	spq_pkg::entry_t     res_q;
	logic [spq_pkg::CNT_W-1:0] count_q;
	logic [spq_pkg::CNT_W-1:0] held_d;

	// operand latch
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q        <= spq_pkg::op_t'(operation);
			opnd_q.node   <= node_in[spq_pkg::NODE_BITS-1:0];
			opnd_q.parent <= parent_in[spq_pkg::NODE_BITS-1:0];
			opnd_q.prio   <= priority_in[spq_pkg::PRIO_BITS-1:0];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		spq_pkg::entry_t l_entry, r_entry;
		logic            l_valid, l_after, r_valid, s_in;
		if (i == 0) begin : g_head
			assign l_entry = opnd_q;
			assign l_valid = 1'b0;
			assign l_after = 1'b0;
			assign s_in    = 1'b0;
		end else begin : g_mid
			assign l_entry = cell_entry[i-1];
			assign l_valid = cell_valid[i-1];
			assign l_after = cell_after[i-1];
			assign s_in    = cell_seen[i-1];
		end
		if (i == N-1) begin : g_tail
			assign r_entry = opnd_q;
			assign r_valid = 1'b0;
		end else begin : g_body
			assign r_entry = cell_entry[i+1];
			assign r_valid = cell_valid[i+1];
		end
		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (co.cmd),
			.rm_head     (co.rm_head),
			.new_entry   (opnd_q),
			.left_entry  (l_entry),
			.left_valid  (l_valid),
			.left_after  (l_after),
			.right_entry (r_entry),
			.right_valid (r_valid),
			.seen_in     (s_in),
			.entry       (cell_entry[i]),
			.valid       (cell_valid[i]),
			.after       (cell_after[i]),
			.seen_out    (cell_seen[i]),
			.first       (cell_first[i])
		);
	end

	// at most one cell flags first match
	always_comb begin
		match_entry = '0;
		for (int i = 0; i < N; i++)
			match_entry = match_entry | (cell_first[i] ? cell_entry[i] : '0);
	end

	assign ci.in_valid = in_valid;
	assign ci.op       = op_q;
	assign ci.empty    = (held_q == '0);
	assign ci.full     = (held_q == spq_pkg::CNT_W'(N));
	assign ci.found    = cell_seen[N-1];
	assign ci.out_free = !out_valid_q || out_ready;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.ci     (ci),
		.co     (co)
	);

	assign in_ready = co.in_ready;

	always_comb begin
		case (co.cmd)
			spq_pkg::CMD_INSERT: held_d = held_q + spq_pkg::CNT_W'(1);
			spq_pkg::CMD_REMOVE: held_d = held_q - spq_pkg::CNT_W'(1);
			default:             held_d = held_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_q <= '0;
		else
			held_q <= held_d;
	end

	always_comb begin
		case (co.dsel)
			spq_pkg::D_HEAD:  res_entry = cell_entry[0];
			spq_pkg::D_MATCH: res_entry = match_entry;
			default:          res_entry = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (co.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (co.out_load) begin
			status_q <= co.status;
			res_q    <= res_entry;
			count_q  <= held_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign node_out     = 8'(res_q.node);
	assign parent_out   = 8'(res_q.parent);
	assign priority_out = 16'(res_q.prio);
	assign entry_count  = 6'(count_q);

endmodule
`default_nettype wire
